>>> sv/qesm_pkg.sv
// Shared widths, codes and controller/datapath interface types for the encoder speed meter.
`default_nettype none

package qesm_pkg;

    // Field widths
    localparam int TS_W       = 32;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int STALE_W    = 4;
    localparam int VALUE_W    = 32;
    localparam int DEN_W      = TS_W + GAIN_W;          // period * gain
    localparam int VOLT_NUM_W = SAMPLE_W + GAIN_W + 6;  // sample * gain * 33

    // Stream packing: tdata = {adc_sample, timestamp_us, other_level, rising, channel}
    localparam int IN_TDATA_W  = 56;
    localparam int IN_CH_BIT   = 0;
    localparam int IN_RISE_BIT = 1;
    localparam int IN_OTH_BIT  = 2;
    localparam int IN_TS_LSB   = 3;
    localparam int IN_ADC_LSB  = IN_TS_LSB + TS_W;
    localparam int OUT_TDATA_W = VALUE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd256;

    // Codes
    localparam logic MODE_ANALOG = 1'b0;
    localparam logic MODE_SPEED  = 1'b1;
    localparam logic ACT_EDGE    = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam logic CH_A        = 1'b0;

    // Voltage: floor(x / 655360) = floor(floor(x / 65536) / 10), x = sample * gain * 33.
    // The divide by 10 is a reciprocal multiply, exact while y = x / 65536 is below 2^22.
    localparam int                  VOLT_Y_W   = VOLT_NUM_W - 16;
    localparam logic [VOLT_Y_W-1:0] VOLT_RECIP = 22'd3355444;   // ceil(2^25 / 10)
    localparam int                  VOLT_SHIFT = 25;

    // Parameter defaults
    localparam int DEF_STALE_LIMIT     = 10;
    localparam int DEF_TICK_RATE_HZ    = 1000000;
    localparam int DEF_EDGES_PER_CYCLE = 4;

    // Controller -> datapath
    typedef struct packed {
        logic take;   // item accepted this cycle
        logic mul;    // form the product
        logic load;   // set up the divider
        logic step;   // one divider step
        logic emit;   // move result into the output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_read;   // incoming item is a read request
        logic fast;      // read answered without the divider
        logic div_last;  // final divider step
        logic out_free;  // output register can take a result
    } t_status;

endpackage

`default_nettype wire

>>> sv/qesm_dpath.sv
// Datapath: encoder state, config registers, multipliers, restoring divider, output register.
`default_nettype none

module qesm_dpath #(
    parameter int STALE_LIMIT     = qesm_pkg::DEF_STALE_LIMIT,
    parameter int TICK_RATE_HZ    = qesm_pkg::DEF_TICK_RATE_HZ,
    parameter int EDGES_PER_CYCLE = qesm_pkg::DEF_EDGES_PER_CYCLE
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [qesm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [qesm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire  [qesm_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  wire                                 i_tuser,
    input  qesm_pkg::t_cmd                      i_cmd,
    output qesm_pkg::t_status                   o_status,
    output logic                                o_tvalid,
    input  wire                                 i_tready,
    output logic [qesm_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic                                o_tuser
);
    import qesm_pkg::*;

    localparam logic [63:0] SPD_NUM = 64'(EDGES_PER_CYCLE) * 64'd60 *
                                      64'(TICK_RATE_HZ) * 64'd65536;
    localparam int NUM_W = $clog2(SPD_NUM + 64'd1);
    localparam int DIV_W = (NUM_W > VOLT_NUM_W) ? NUM_W : VOLT_NUM_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Config
    logic                r_mode;
    logic [GAIN_W-1:0]   r_gain;
    // Encoder state
    logic [TS_W-1:0]     r_last;
    logic [TS_W-1:0]     r_period;
    logic                r_dir;
    logic [STALE_W-1:0]  r_stale;
    // Read in flight
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_pos;
    logic                r_fast;
    logic [DIV_W-1:0]    r_fast_mag;
    logic [DEN_W-1:0]    r_prod;
    // Divider
    logic [DIV_W-1:0]    r_quot;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [CNT_W-1:0]    r_cnt;
    // Output
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_data;
    logic                r_out_sat;

    // Input unpack
    logic                in_ch, in_rise, in_oth;
    logic [TS_W-1:0]     in_ts;
    logic [SAMPLE_W-1:0] in_adc;
    assign in_ch   = i_tdata[IN_CH_BIT];
    assign in_rise = i_tdata[IN_RISE_BIT];
    assign in_oth  = i_tdata[IN_OTH_BIT];
    assign in_ts   = i_tdata[IN_TS_LSB +: TS_W];
    assign in_adc  = i_tdata[IN_ADC_LSB +: SAMPLE_W];

    // Read classification
    logic spd, stale_ok, per_ok, gain_ok;
    assign spd      = (r_mode == MODE_SPEED);
    assign stale_ok = (r_stale < STALE_W'(STALE_LIMIT));
    assign per_ok   = (r_period != '0) && !r_period[TS_W-1];
    assign gain_ok  = (r_gain != '0);

    // Divider step
    logic [DEN_W:0]       trial;
    logic                 ge;
    logic [DEN_W:0]       diff;
    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    logic [TS_W-1:0]       mul_a;
    logic [VOLT_NUM_W-1:0] volt_num;
    logic [2*VOLT_Y_W-1:0] volt_prod;
    assign mul_a    = spd ? r_period : TS_W'(r_sample);
    assign volt_num = VOLT_NUM_W'({r_prod[TS_W-1:0], 5'b0}) + VOLT_NUM_W'(r_prod[TS_W-1:0]);
    // voltage: quotient register holds x / 65536 here, times ceil(2^25 / 10)
    assign volt_prod = (2*VOLT_Y_W)'(r_quot[VOLT_Y_W-1:0]) * (2*VOLT_Y_W)'(VOLT_RECIP);

    // Signed clip of the magnitude
    logic [DIV_W-1:0]   mag;
    logic [VALUE_W-1:0] n_out_data;
    logic               n_out_sat;
    always_comb begin
        mag = r_fast ? r_fast_mag : r_quot;
        if (r_pos) begin
            n_out_sat  = (mag > DIV_W'(32'h7FFF_FFFF));
            n_out_data = n_out_sat ? 32'h7FFF_FFFF : mag[VALUE_W-1:0];
        end else begin
            n_out_sat  = (mag > DIV_W'(32'h8000_0000));
            n_out_data = n_out_sat ? 32'h8000_0000 : (32'd0 - mag[VALUE_W-1:0]);
        end
    end

    always_comb begin
        o_status.is_read  = (i_tuser == ACT_READ);
        o_status.fast     = spd && !(stale_ok && per_ok && gain_ok);
        o_status.div_last = (r_cnt == CNT_W'(1));
        o_status.out_free = !r_out_valid || i_tready;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ANALOG;
            r_gain      <= GAIN_RESET;
            r_last      <= '0;
            r_period    <= '0;
            r_dir       <= 1'b0;
            r_stale     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: r_mode <= i_cfg_data[0];
                    CFG_GAIN: r_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take && i_tuser == ACT_EDGE) begin
                r_dir <= in_oth ^ in_ch ^ in_rise;
                if (in_ch == CH_A && in_rise) begin
                    r_period <= in_ts - r_last;
                    r_last   <= in_ts;
                    r_stale  <= '0;
                end
            end
            if (i_cmd.take && i_tuser == ACT_READ && spd && stale_ok) begin
                r_stale <= r_stale + STALE_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample   <= in_adc;
            r_pos      <= spd ? r_dir : 1'b1;
            r_fast     <= spd && !(stale_ok && per_ok && gain_ok);
            // zero gain with a live period clips to the direction's limit
            r_fast_mag <= (spd && stale_ok && per_ok && !gain_ok) ? '1 : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= DEN_W'(mul_a) * DEN_W'(r_gain);
        end
        if (i_cmd.load) begin
            r_quot <= spd ? DIV_W'(SPD_NUM) : DIV_W'(volt_num[VOLT_NUM_W-1:16]);
            r_den  <= r_prod;
            r_rem  <= '0;
            // voltage needs a single reciprocal step
            r_cnt  <= spd ? CNT_W'(DIV_W) : CNT_W'(1);
        end
        if (i_cmd.step) begin
            if (spd) begin
                r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], ge};
            end else begin
                r_quot <= DIV_W'(volt_prod[2*VOLT_Y_W-1:VOLT_SHIFT]);
            end
            r_cnt  <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
            r_out_sat  <= n_out_sat;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_sat;

    a_stale_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stale <= STALE_W'(STALE_LIMIT))
        else $error("stale count above limit");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && spd) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_volt_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_mode == MODE_ANALOG) |-> !n_out_sat)
        else $error("voltage result clipped");

endmodule

`default_nettype wire

>>> sv/qesm_ctrl.sv
// Controller: one-hot sequencer for accept, multiply, divide and result hand-off.
`default_nettype none

module qesm_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  qesm_pkg::t_status           i_status,
    output qesm_pkg::t_cmd              o_cmd
);
    import qesm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid && i_status.is_read) begin
                    n_state = i_status.fast ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_status.is_read && !i_status.fast) |=> ##1 (r_state == S_LOAD))
        else $error("divide-path read did not reach divider setup");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_status.out_free) |=> (r_state == S_DONE))
        else $error("finished result dropped while output busy");

endmodule

`default_nettype wire

>>> sv/quadrature_encoder_speed_meter.sv
// Top level: quadrature encoder speed meter with analog voltage readout.
// Usage:
//   Input stream (s_axis_*): one item per encoder edge (tuser = 0) or read request
//   (tuser = 1). Edge items update direction and, on channel A rising edges, the
//   period between A rises; they give no result. A read gives one result item.
//   Output stream (m_axis_*): tdata = signed Q23.8 value, tuser = saturated flag.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_data; index 0 = mode, 1 = gain (Q8.8).
//   Write it only while the block is idle.
// Flow (accept to result valid; the next item can be taken once it is valid):
//   Edge items: one per cycle while the block is idle, no result. Speed reads
//   answered without division (stale, zero or negative period, zero gain) go
//   straight to the result hand-off. Voltage reads: product, shift-add by 33 and
//   a reciprocal multiply for the divide by 10. Other speed reads go through the
//   restoring divider, one quotient bit per cycle, DIV_W = max(bits of
//   EDGES_PER_CYCLE*60*TICK_RATE_HZ*65536, 38). One item is worked on at a time.
// Reset: synchronous, active low; mode = analog, gain = 1.0, encoder state zero.
// Stall: the result sits in an output register; edge items and a new read are
//   still taken, and a finished read waits in place until that register frees.
`default_nettype none

module quadrature_encoder_speed_meter #(
    parameter int STALE_LIMIT     = qesm_pkg::DEF_STALE_LIMIT,
    parameter int TICK_RATE_HZ    = qesm_pkg::DEF_TICK_RATE_HZ,
    parameter int EDGES_PER_CYCLE = qesm_pkg::DEF_EDGES_PER_CYCLE
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [qesm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [qesm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] channel, [1] rising, [2] other_level, [34:3] timestamp_us,
    // [50:35] adc_sample, [55:51] zero
    input  wire  [qesm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] action
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [31:0] value
    output logic [qesm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] saturated
    output logic                                m_axis_tuser
);
    import qesm_pkg::*;

    t_cmd    cmd;
    t_status status;

    qesm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    qesm_dpath #(
        .STALE_LIMIT     (STALE_LIMIT),
        .TICK_RATE_HZ    (TICK_RATE_HZ),
        .EDGES_PER_CYCLE (EDGES_PER_CYCLE)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser)
    );

endmodule

`default_nettype wire
